// File: hw/rtl/assert_macros.svh
// Assertion helpers for the fraction unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk outside reset.
`define RAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define RAU_IMPLY(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

`endif

// File: hw/rtl/rau_pkg.sv
`default_nettype none
package rau_pkg;
  localparam int unsigned OPERAND_WIDTH = 64;
  localparam int unsigned WORD_W        = 64;
  localparam int unsigned WIDE_W        = 128;

  typedef enum logic [2:0] {
    OP_NORM = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_CMP  = 3'd5
  } opcode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NORM,
    S_M1,
    S_M2,
    S_M3,
    S_COMB,
    S_RED,
    S_GCD,
    S_DIV1,
    S_DIV2,
    S_FIN
  } state_t;
endpackage
`default_nettype wire

// File: hw/rtl/rational_arithmetic_unit.sv
`default_nettype none
// Channel   Ports                                             Handshake
// request   in_opcode, in_a_num, in_a_den, in_b_num, in_b_den start & !busy
// result    out_res_num, out_res_den, out_order,              out_valid, one cycle
//           out_divide_by_zero, out_overflow
//
// One request at a time; busy stays high until its result has been shown.
// Work per request: up to three products on the shift-add multiplier, a binary
// gcd (one shift, swap or subtract of a 128-bit pair a cycle), and the two
// quotient divisions; not every opcode needs all of them.
// Reset (rst_n low, synchronous) returns the sequencer to idle.
// The receiver cannot stall: out_valid is high for exactly one cycle.
`include "assert_macros.svh"
module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [2:0]         in_opcode,
  input  wire logic signed [63:0] in_a_num,
  input  wire logic signed [63:0] in_a_den,
  input  wire logic signed [63:0] in_b_num,
  input  wire logic signed [63:0] in_b_den,
  output logic                    out_valid,
  output logic signed [63:0]      out_res_num,
  output logic [62:0]             out_res_den,
  output logic signed [1:0]       out_order,
  output logic                    out_divide_by_zero,
  output logic                    out_overflow
);
  localparam int unsigned W  = rau_pkg::WORD_W;
  localparam int unsigned WW = rau_pkg::WIDE_W;
  localparam int unsigned SH = W - OPERAND_WIDTH;
  localparam logic [WW-1:0] LIM = WW'(1) << (OPERAND_WIDTH - 1);

  rau_pkg::state_t state_r, state_nxt;

  logic [2:0]    op_r;
  logic [W-1:0]  an_r, ad_r, bn_r, bd_r;
  logic          aneg_r, bneg_r;
  logic [WW-1:0] p1_r, p2_r, p3_r;
  logic [WW-1:0] rnum_r, rden_r, ga_r, gb_r, g_r, qn_r, qd_r;
  logic          rneg_r, dz_r;
  logic [1:0]    ord_r;
  logic [6:0]    k_r;
  logic          ov_r, outv_r;
  logic [W-1:0]  onum_r;
  logic [62:0]   oden_r;

  // operand conditioning
  function automatic logic [W-1:0] sx(input logic [W-1:0] v);
    sx = W'($signed(v << SH) >>> SH);
  endfunction
  function automatic logic [W-1:0] mg(input logic [W-1:0] v);
    mg = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [W-1:0] xan, xad, xbn, xbd;
  assign xan = sx(in_a_num);
  assign xad = (sx(in_a_den) == '0) ? W'(1) : sx(in_a_den);
  assign xbn = sx(in_b_num);
  assign xbd = (sx(in_b_den) == '0) ? W'(1) : sx(in_b_den);

  // multiplier and divider
  logic          mul_start, mul_done, div_start, div_done;
  logic [W-1:0]  mx, my;
  logic [WW-1:0] prod, dvd, dvs, quot;

  rau_mul u_mul (.clk, .rst_n, .start(mul_start), .a(mx), .b(my),
                 .done(mul_done), .prod);
  rau_div u_div (.clk, .rst_n, .start(div_start), .dividend(dvd), .divisor(dvs),
                 .done(div_done), .quot);

  // signed combine of the cross products
  logic          sb, ge, csign;
  logic [WW-1:0] cmag;
  always_comb begin
    if (op_r == rau_pkg::OP_CMP)
      sb = ~bneg_r;
    else if (op_r == rau_pkg::OP_SUB && bn_r != '0)
      sb = ~bneg_r;
    else
      sb = bneg_r;
    ge = (p1_r >= p2_r);
    if (aneg_r == sb) begin
      cmag  = p1_r + p2_r;
      csign = aneg_r;
    end else begin
      cmag  = ge ? (p1_r - p2_r) : (p2_r - p1_r);
      csign = (cmag == '0) ? 1'b0 : (ge ? aneg_r : sb);
    end
  end

  logic [WW:0] gdiff;
  assign gdiff = {1'b0, gb_r} - {1'b0, ga_r};

  always_comb begin
    state_nxt = state_r;
    mul_start = 1'b0;
    div_start = 1'b0;
    mx        = an_r;
    my        = (op_r == rau_pkg::OP_MUL) ? bn_r : bd_r;
    dvd       = rnum_r;
    dvs       = ga_r << k_r;
    case (state_r)
      rau_pkg::S_IDLE: if (start && !busy) state_nxt = rau_pkg::S_NORM;
      rau_pkg::S_NORM: begin
        if (op_r == rau_pkg::OP_NORM || (op_r == rau_pkg::OP_DIV && bn_r == '0))
          state_nxt = rau_pkg::S_RED;
        else if (op_r inside {rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL,
                              rau_pkg::OP_DIV, rau_pkg::OP_CMP}) begin
          mul_start = 1'b1;
          state_nxt = rau_pkg::S_M1;
        end else
          state_nxt = rau_pkg::S_FIN;
      end
      rau_pkg::S_M1: begin
        mx = bn_r;
        my = ad_r;
        if (mul_done) begin
          mul_start = 1'b1;
          state_nxt = rau_pkg::S_M2;
        end
      end
      rau_pkg::S_M2: begin
        mx = ad_r;
        my = (op_r == rau_pkg::OP_DIV) ? bn_r : bd_r;
        if (mul_done) begin
          mul_start = 1'b1;
          state_nxt = rau_pkg::S_M3;
        end
      end
      rau_pkg::S_M3:  if (mul_done) state_nxt = rau_pkg::S_COMB;
      rau_pkg::S_COMB:
        state_nxt = (op_r == rau_pkg::OP_CMP) ? rau_pkg::S_FIN : rau_pkg::S_RED;
      rau_pkg::S_RED:
        state_nxt = (rnum_r == '0) ? rau_pkg::S_FIN : rau_pkg::S_GCD;
      rau_pkg::S_GCD: begin
        if (ga_r[0] && gb_r == '0) begin
          div_start = 1'b1;
          state_nxt = rau_pkg::S_DIV1;
        end
      end
      rau_pkg::S_DIV1: begin
        dvd = rden_r;
        dvs = g_r;
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = rau_pkg::S_DIV2;
        end
      end
      rau_pkg::S_DIV2: if (div_done) state_nxt = rau_pkg::S_FIN;
      rau_pkg::S_FIN:  state_nxt = rau_pkg::S_IDLE;
      default:         state_nxt = rau_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rau_pkg::S_IDLE;
      outv_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      outv_r  <= (state_r == rau_pkg::S_FIN);
    end
  end

  logic ov_c;
  assign ov_c = (qd_r >= LIM) || (rneg_r ? (qn_r > LIM) : (qn_r >= LIM));

  always_ff @(posedge clk) begin
    case (state_r)
      rau_pkg::S_IDLE: begin
        op_r   <= in_opcode;
        an_r   <= mg(xan);
        ad_r   <= (xan == '0) ? W'(1) : mg(xad);
        bn_r   <= mg(xbn);
        bd_r   <= (xbn == '0) ? W'(1) : mg(xbd);
        aneg_r <= (xan != '0) && (xan[W-1] ^ xad[W-1]);
        bneg_r <= (xbn != '0) && (xbn[W-1] ^ xbd[W-1]);
        dz_r   <= 1'b0;
        ord_r  <= 2'b00;
        qn_r   <= '0;
        qd_r   <= WW'(1);
      end
      rau_pkg::S_NORM: begin
        rnum_r <= WW'(an_r);
        rden_r <= WW'(ad_r);
        rneg_r <= aneg_r;
        dz_r   <= (op_r == rau_pkg::OP_DIV) && (bn_r == '0);
      end
      rau_pkg::S_M1: if (mul_done) p1_r <= prod;
      rau_pkg::S_M2: if (mul_done) p2_r <= prod;
      rau_pkg::S_M3: if (mul_done) p3_r <= prod;
      rau_pkg::S_COMB: begin
        rden_r <= p3_r;
        if (op_r == rau_pkg::OP_ADD || op_r == rau_pkg::OP_SUB) begin
          rnum_r <= cmag;
          rneg_r <= csign;
        end else begin
          rnum_r <= p1_r;
          rneg_r <= aneg_r ^ bneg_r;
        end
        if (op_r == rau_pkg::OP_CMP)
          ord_r <= (cmag == '0) ? 2'b00 : (csign ? 2'b11 : 2'b01);
      end
      rau_pkg::S_RED: begin
        ga_r <= rnum_r;
        gb_r <= rden_r;
        k_r  <= '0;
      end
      rau_pkg::S_GCD: begin
        // binary gcd, one step a cycle
        if (!ga_r[0] && !gb_r[0]) begin
          ga_r <= ga_r >> 1;
          gb_r <= gb_r >> 1;
          k_r  <= k_r + 1'b1;
        end else if (!ga_r[0]) begin
          ga_r <= ga_r >> 1;
        end else if (gb_r == '0) begin
          g_r <= ga_r << k_r;
        end else if (!gb_r[0]) begin
          gb_r <= gb_r >> 1;
        end else if (gdiff[WW]) begin
          ga_r <= gb_r;
          gb_r <= ga_r;
        end else begin
          gb_r <= gdiff[WW-1:0];
        end
      end
      rau_pkg::S_DIV1: if (div_done) qn_r <= quot;
      rau_pkg::S_DIV2: if (div_done) qd_r <= quot;
      rau_pkg::S_FIN: begin
        ov_r   <= ov_c;
        onum_r <= ov_c ? '0 : (rneg_r ? (~qn_r[W-1:0] + 1'b1) : qn_r[W-1:0]);
        oden_r <= ov_c ? 63'd1 : qd_r[62:0];
      end
      default: ;
    endcase
  end

  assign busy               = (state_r != rau_pkg::S_IDLE) || outv_r;
  assign out_valid          = outv_r;
  assign out_res_num        = onum_r;
  assign out_res_den        = oden_r;
  assign out_order          = ord_r;
  assign out_divide_by_zero = dz_r;
  assign out_overflow       = ov_r;

  `RAU_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted request did not raise busy")
  `RAU_ASSERT(a_single_pulse, out_valid |=> !out_valid, "result strobe longer than one cycle")
  `RAU_IMPLY(a_ovf_zero, out_valid && out_overflow, out_res_num == '0 && out_res_den == 63'd1,
             "overflow result is not 0/1")
  `RAU_IMPLY(a_dz_order, out_valid && out_divide_by_zero, out_order == 2'b00,
             "divide by zero with nonzero order")
endmodule
`default_nettype wire

// File: hw/rtl/rau_mul.sv
`default_nettype none
// Shift-add multiplier, one multiplier bit per cycle.
module rau_mul (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [rau_pkg::WORD_W-1:0]    a,
  input  wire logic [rau_pkg::WORD_W-1:0]    b,
  output logic                               done,
  output logic [rau_pkg::WIDE_W-1:0]         prod
);
  localparam int unsigned CNT_W = $clog2(rau_pkg::WORD_W) + 1;

  logic [rau_pkg::WORD_W-1:0] a_r, hi_r, lo_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       run_r, done_r;
  logic [rau_pkg::WORD_W:0]   sum;

  assign sum = {1'b0, hi_r} + {1'b0, (lo_r[0] ? a_r : '0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(rau_pkg::WORD_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (run_r) begin
      hi_r <= sum[rau_pkg::WORD_W:1];
      lo_r <= {sum[0], lo_r[rau_pkg::WORD_W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};
endmodule
`default_nettype wire

// File: hw/rtl/rau_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module rau_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [rau_pkg::WIDE_W-1:0]  dividend,
  input  wire logic [rau_pkg::WIDE_W-1:0]  divisor,
  output logic                             done,
  output logic [rau_pkg::WIDE_W-1:0]       quot
);
  localparam int unsigned CNT_W = $clog2(rau_pkg::WIDE_W) + 1;

  logic [rau_pkg::WIDE_W-1:0] q_r, r_r, d_r;
  logic [CNT_W-1:0]           cnt_r;
  logic                       run_r, done_r;
  logic [rau_pkg::WIDE_W:0]   rs, diff;

  assign rs   = {r_r, q_r[rau_pkg::WIDE_W-1]};
  assign diff = rs - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(rau_pkg::WIDE_W);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r <= dividend;
      r_r <= '0;
      d_r <= divisor;
    end else if (run_r) begin
      // keep the partial remainder when the trial subtract borrows
      if (diff[rau_pkg::WIDE_W]) begin
        r_r <= rs[rau_pkg::WIDE_W-1:0];
        q_r <= {q_r[rau_pkg::WIDE_W-2:0], 1'b0};
      end else begin
        r_r <= diff[rau_pkg::WIDE_W-1:0];
        q_r <= {q_r[rau_pkg::WIDE_W-2:0], 1'b1};
      end
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire
